// ===== hdl/amd_pkg.sv =====
// Shared types and constants of the answering-machine event classifier.
// Holds field widths, item and verdict codes, register indexes and the queue entry type.
// No dependencies.
package amd_pkg;

  localparam int CHANNELS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 8;

  localparam int MODE_W     = 2;
  localparam int CH_W       = 6;
  localparam int EV_W       = 4;
  localparam int VERDICT_W  = 2;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int QDEPTH     = 2;

  localparam logic [MODE_W-1:0] MODE_EVENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  localparam logic [EV_W-1:0] EV_IGN_FIRST  = 4'd0;
  localparam logic [EV_W-1:0] EV_IGN_LAST   = 4'd3;
  localparam logic [EV_W-1:0] EV_SIL_MIN    = 4'd4;
  localparam logic [EV_W-1:0] EV_SIL_TONE   = 4'd5;
  localparam logic [EV_W-1:0] EV_SIL_PERSON = 4'd6;
  localparam logic [EV_W-1:0] EV_SIL_TOUT   = 4'd7;
  localparam logic [EV_W-1:0] EV_VOC_MIN    = 4'd8;
  localparam logic [EV_W-1:0] EV_MUSIC      = 4'd9;
  localparam logic [EV_W-1:0] EV_VOC_TOUT   = 4'd10;

  localparam logic [VERDICT_W-1:0] V_NONE   = 2'd0;
  localparam logic [VERDICT_W-1:0] V_MUSIC  = 2'd1;
  localparam logic [VERDICT_W-1:0] V_PERSON = 2'd2;
  localparam logic [VERDICT_W-1:0] V_TONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_VOICE_THR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIL_THR   = 4'd1;

  localparam logic [THR_W-1:0] VOICE_THR_RST = 8'd4;
  localparam logic [THR_W-1:0] SIL_THR_RST   = 8'd1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_EVENT,
    OP_START,
    OP_STOP
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] channel;
    logic [EV_W-1:0] event_code;
  } item_t;

endpackage

// ===== hdl/amd_if.sv =====
// Handshake channels of the answering-machine event classifier.
// Event input, configuration write and verdict output; depends on amd_pkg.
interface amd_evt_if;
  logic                         valid;
  logic                         ready;
  logic [amd_pkg::MODE_W-1:0]   mode;
  logic [amd_pkg::CH_W-1:0]     channel;
  logic [amd_pkg::EV_W-1:0]     event_code;
  modport source (output valid, mode, channel, event_code, input ready);
  modport sink (input valid, mode, channel, event_code, output ready);
endinterface

interface amd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [amd_pkg::CFG_IDX_W-1:0]  index;
  logic [amd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface amd_res_if;
  logic                          valid;
  logic                          ready;
  logic [amd_pkg::VERDICT_W-1:0] verdict;
  logic [amd_pkg::CH_W-1:0]      verdict_channel;
  modport source (output valid, verdict, verdict_channel, input ready);
  modport sink (input valid, verdict, verdict_channel, output ready);
endinterface

// ===== hdl/answer_machine_event_classifier.sv =====
// Top level of the answering-machine event classifier.
// Instantiates amd_front, amd_queue and amd_back; depends on amd_pkg and amd_if.
//
// The block accepts one item per clock cycle while its queue is not full and returns
// exactly one result per item, in order. An accepted item waits in the two-entry queue,
// whose head addresses the registered read of the per-channel state memory; after that
// register the verdict is computed, the state is written back and the result register is
// loaded. The per-channel read-modify-write sets the rate; an item for the channel just
// written reads the new state through a bypass register. State starts cleared by per-channel
// valid bits, so no clearing pass follows reset. Thresholds may be written only while the
// block is idle.
module answer_machine_event_classifier #(
  parameter int CHANNELS   = amd_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = amd_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amd_evt_if.sink   evt_i,
  amd_cfg_if.sink   cfg_i,
  amd_res_if.source res_o
);

  logic                      push;
  logic                      full;
  amd_pkg::item_t            push_item;
  logic                      q_vld;
  logic                      q_pop;
  amd_pkg::item_t            q_item;
  logic [amd_pkg::THR_W-1:0] voice_thr;
  logic [amd_pkg::THR_W-1:0] sil_thr;

  amd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .cfg_i       (cfg_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item),
    .voice_thr_o (voice_thr),
    .sil_thr_o   (sil_thr)
  );

  amd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .vld_o  (q_vld),
    .item_o (q_item),
    .pop_i  (q_pop)
  );

  amd_back #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .voice_thr_i (voice_thr),
    .sil_thr_i   (sil_thr),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/amd_front.sv =====
// Front end: accepts items, classifies them into queue operations and holds the thresholds.
// Depends on amd_pkg and amd_if.
module amd_front #(
  parameter int CHANNELS = amd_pkg::CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  amd_evt_if.sink                   evt_i,
  amd_cfg_if.sink                   cfg_i,
  input  logic                      full_i,
  output logic                      push_o,
  output amd_pkg::item_t            item_o,
  output logic [amd_pkg::THR_W-1:0] voice_thr_o,
  output logic [amd_pkg::THR_W-1:0] sil_thr_o
);

  logic [amd_pkg::THR_W-1:0] voice_thr_q;
  logic [amd_pkg::THR_W-1:0] sil_thr_q;

  assign evt_i.ready = !full_i;
  assign push_o      = evt_i.valid && !full_i;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    item_o.op         = amd_pkg::OP_NOP;
    item_o.channel    = evt_i.channel;
    item_o.event_code = evt_i.event_code;
    if (32'(evt_i.channel) < CHANNELS) begin
      case (evt_i.mode)
        amd_pkg::MODE_EVENT: item_o.op = amd_pkg::OP_EVENT;
        amd_pkg::MODE_START: item_o.op = amd_pkg::OP_START;
        amd_pkg::MODE_STOP:  item_o.op = amd_pkg::OP_STOP;
        default:             item_o.op = amd_pkg::OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_thr_q <= amd_pkg::VOICE_THR_RST;
      sil_thr_q   <= amd_pkg::SIL_THR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        amd_pkg::REG_VOICE_THR: voice_thr_q <= cfg_i.data;
        amd_pkg::REG_SIL_THR:   sil_thr_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign voice_thr_o = voice_thr_q;
  assign sil_thr_o   = sil_thr_q;

endmodule

// ===== hdl/amd_queue.sv =====
// Short queue that decouples the classifying front end from the channel back end.
// Depends on amd_pkg.
module amd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  amd_pkg::item_t item_i,
  output logic           full_o,
  output logic           vld_o,
  output amd_pkg::item_t item_o,
  input  logic           pop_i
);

  localparam int PtrW = (amd_pkg::QDEPTH > 1) ? $clog2(amd_pkg::QDEPTH) : 1;
  localparam int CntW = $clog2(amd_pkg::QDEPTH + 1);

  amd_pkg::item_t  ent_q [amd_pkg::QDEPTH];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  assign full_o = (cnt_q == CntW'(amd_pkg::QDEPTH));
  assign vld_o  = (cnt_q != '0);
  assign item_o = ent_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> vld_o) else $error("queue read while empty");
`endif

endmodule

// ===== hdl/amd_back.sv =====
// Back end: per-channel state memory with read-modify-write, verdict logic and result register.
// Depends on amd_pkg and amd_if.
module amd_back #(
  parameter int CHANNELS   = amd_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = amd_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_vld_i,
  input  amd_pkg::item_t            q_item_i,
  output logic                      q_pop_o,
  input  logic [amd_pkg::THR_W-1:0] voice_thr_i,
  input  logic [amd_pkg::THR_W-1:0] sil_thr_i,
  amd_res_if.source                 res_o
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CmpW = (COUNT_BITS > amd_pkg::THR_W) ? COUNT_BITS : amd_pkg::THR_W;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic                          en;
    cnt_t                          ssil;
    cnt_t                          tsil;
    cnt_t                          psil;
    cnt_t                          svoc;
    cnt_t                          mus;
    logic                          pflag;
    logic                          tflag;
    logic [amd_pkg::EV_W-1:0]      prev;
    logic [amd_pkg::VERDICT_W-1:0] last;
  } rec_t;

  rec_t                          mem_q [CHANNELS];
  logic [CHANNELS-1:0]           vld_q;
  logic                          s2_vld_q;
  amd_pkg::item_t                s2_item_q;
  rec_t                          s2_rd_q;
  logic                          s2_mvld_q;
  logic                          s2_byp_q;
  rec_t                          s2_byp_rec_q;
  logic                          out_vld_q;
  logic [amd_pkg::VERDICT_W-1:0] out_verdict_q;
  logic [amd_pkg::CH_W-1:0]      out_ch_q;

  logic                          s2_fire;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_idx;
  logic [IdxW-1:0]               rd_idx;
  rec_t                          cur;
  rec_t                          nxt;
  logic [amd_pkg::VERDICT_W-1:0] verdict;
  logic [amd_pkg::EV_W-1:0]      ev;

  assign s2_fire = s2_vld_q && (!out_vld_q || res_o.ready);
  assign q_pop_o = q_vld_i && (!s2_vld_q || s2_fire);
  assign rd_idx  = IdxW'(q_item_i.channel);
  assign wr_idx  = IdxW'(s2_item_q.channel);
  assign wr_en   = s2_fire && (s2_item_q.op != amd_pkg::OP_NOP);
  assign ev      = s2_item_q.event_code;

  always_comb begin
    if (s2_byp_q) begin
      cur = s2_byp_rec_q;
    end else if (s2_mvld_q) begin
      cur = s2_rd_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    nxt     = cur;
    verdict = amd_pkg::V_NONE;
    case (s2_item_q.op)
      amd_pkg::OP_START: begin
        nxt    = '0;
        nxt.en = 1'b1;
      end
      amd_pkg::OP_STOP: begin
        nxt = '0;
      end
      amd_pkg::OP_EVENT: begin
        if (!cur.en) begin
          nxt = '0;
        end else begin
          if (!(ev inside {[amd_pkg::EV_IGN_FIRST:amd_pkg::EV_IGN_LAST]})) begin
            case (ev)
              amd_pkg::EV_SIL_MIN: begin
                if (nxt.ssil != '1) nxt.ssil = nxt.ssil + 1'b1;
              end
              amd_pkg::EV_SIL_TONE: begin
                if (nxt.tsil != '1) nxt.tsil = nxt.tsil + 1'b1;
                if (cur.prev == amd_pkg::EV_SIL_MIN && nxt.ssil != '0) begin
                  nxt.ssil = nxt.ssil - 1'b1;
                end
              end
              amd_pkg::EV_SIL_PERSON: begin
                if (nxt.tsil != '0 && cur.prev == amd_pkg::EV_SIL_TONE) begin
                  nxt.tsil  = nxt.tsil - 1'b1;
                  nxt.tflag = 1'b0;
                end
                if (nxt.svoc != '0 || nxt.mus != '0) begin
                  if (nxt.psil == '0) nxt.pflag = 1'b0;
                  if (nxt.psil != '1) nxt.psil = nxt.psil + 1'b1;
                end
              end
              amd_pkg::EV_SIL_TOUT: begin
                if (cur.prev == amd_pkg::EV_SIL_PERSON && nxt.psil != '0) begin
                  nxt.psil = nxt.psil - 1'b1;
                end
              end
              amd_pkg::EV_VOC_MIN: begin
                if (nxt.svoc != '1) nxt.svoc = nxt.svoc + 1'b1;
                if (nxt.psil != '0) nxt.pflag = 1'b1;
                if (nxt.tsil != '0) nxt.tflag = 1'b1;
              end
              amd_pkg::EV_MUSIC: begin
                if (cur.prev == amd_pkg::EV_VOC_MIN && nxt.svoc != '0) begin
                  nxt.svoc = nxt.svoc - 1'b1;
                end
                if (nxt.mus != '1) nxt.mus = nxt.mus + 1'b1;
              end
              amd_pkg::EV_VOC_TOUT: begin
                if (cur.prev == amd_pkg::EV_MUSIC && nxt.mus != '0) begin
                  nxt.mus = nxt.mus - 1'b1;
                end
              end
              default: ;
            endcase
            nxt.prev = ev;
          end
          if (nxt.mus != '0) begin
            nxt.mus   = '0;
            nxt.ssil  = '0;
            nxt.svoc  = '0;
            nxt.tflag = 1'b0;
            nxt.last  = amd_pkg::V_MUSIC;
            verdict   = amd_pkg::V_MUSIC;
          end else if (nxt.pflag && nxt.last != amd_pkg::V_PERSON &&
                       nxt.last != amd_pkg::V_TONE) begin
            nxt.last = amd_pkg::V_PERSON;
            nxt.en   = 1'b0;
            verdict  = amd_pkg::V_PERSON;
          end
          if (nxt.last != amd_pkg::V_PERSON && nxt.last != amd_pkg::V_TONE &&
              CmpW'(nxt.svoc) > CmpW'(voice_thr_i) &&
              CmpW'(nxt.ssil) > CmpW'(sil_thr_i) && nxt.tflag) begin
            nxt.mus   = '0;
            nxt.ssil  = '0;
            nxt.svoc  = '0;
            nxt.tflag = 1'b0;
            nxt.last  = amd_pkg::V_TONE;
            verdict   = amd_pkg::V_TONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= nxt;
    end
    if (q_pop_o) begin
      s2_rd_q      <= mem_q[rd_idx];
      s2_mvld_q    <= vld_q[rd_idx];
      s2_item_q    <= q_item_i;
      s2_byp_q     <= wr_en && (wr_idx == rd_idx);
      s2_byp_rec_q <= nxt;
    end
    if (s2_fire) begin
      out_verdict_q <= verdict;
      out_ch_q      <= s2_item_q.channel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      s2_vld_q  <= q_pop_o || (s2_vld_q && !s2_fire);
      out_vld_q <= s2_fire || (out_vld_q && !res_o.ready);
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.verdict         = out_verdict_q;
  assign res_o.verdict_channel = out_ch_q;

`ifndef SYNTHESIS
  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> out_vld_q) else $error("result lost after stage fire");
  a_ctrl_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_item_q.op != amd_pkg::OP_EVENT |=> out_verdict_q == amd_pkg::V_NONE)
    else $error("verdict on a non-event item");
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(wr_idx)]) else $error("written entry not marked valid");
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && s2_vld_q |-> s2_fire) else $error("stage overwritten while stalled");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of answer_machine_event_classifier: a directed table, saturation
// bursts and random calls are checked against a per-channel predictor of the verdicts.
// Depends on amd_pkg and the amd_*_if interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [amd_pkg::MODE_W-1:0] MODE_UNUSED    = 2'd3;
  localparam logic [amd_pkg::EV_W-1:0]   EV_OTHER_FIRST = 4'd11;
  localparam logic [amd_pkg::EV_W-1:0]   EV_OTHER_LAST  = 4'd15;
  localparam int NCH      = amd_pkg::CHANNELS_DEF;
  localparam int CW       = amd_pkg::COUNT_BITS_DEF;
  localparam int ROWS     = 25;
  localparam int POOL_N   = 6;
  localparam int BURST_N  = 265;
  localparam int HOLD_OFF = 80;

  typedef logic [CW-1:0] count_t;
  typedef logic [amd_pkg::CH_W-1:0] ch_t;
  typedef logic [amd_pkg::EV_W-1:0] ev_t;
  typedef logic [amd_pkg::MODE_W-1:0] mode_t;
  typedef logic [amd_pkg::VERDICT_W-1:0] vcode_t;

  typedef struct packed {
    mode_t  mode;
    ch_t    ch;
    ev_t    ev;
    bit     fixed;
    vcode_t verdict;
  } drive_row_t;

  typedef struct {
    vcode_t verdict;
    ch_t    ch;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  amd_evt_if evt ();
  amd_cfg_if cfg ();
  amd_res_if res ();

  answer_machine_event_classifier dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .cfg_i (cfg),
    .res_o (res)
  );

  always #6 clk_i = ~clk_i;

  logic [amd_pkg::THR_W-1:0] voice_thr = amd_pkg::VOICE_THR_RST;
  logic [amd_pkg::THR_W-1:0] sil_thr   = amd_pkg::SIL_THR_RST;
  bit               chan_on[NCH];
  count_t           short_sil[NCH];
  count_t           tone_sil[NCH];
  count_t           person_sil[NCH];
  count_t           short_voc[NCH];
  count_t           music_cnt[NCH];
  bit               person_seen[NCH];
  bit               tone_seen[NCH];
  ev_t              last_event[NCH];
  vcode_t           last_verdict[NCH];

  verdict_t verdicts_due[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_offs_asked = 0;
  bit row_fixed = 1'b0;
  vcode_t row_verdict = amd_pkg::V_NONE;
  ch_t pool[POOL_N];

  drive_row_t call_rows[ROWS] = '{
    '{amd_pkg::MODE_EVENT, 6'd5,  amd_pkg::EV_SIL_MIN,    1'b1, amd_pkg::V_NONE},
    '{MODE_UNUSED,         6'd63, EV_OTHER_LAST,          1'b1, amd_pkg::V_NONE},
    '{amd_pkg::MODE_START, 6'd0,  amd_pkg::EV_IGN_FIRST,  1'b1, amd_pkg::V_NONE},
    '{amd_pkg::MODE_START, 6'd63, amd_pkg::EV_IGN_FIRST,  1'b1, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd0,  amd_pkg::EV_MUSIC,      1'b1, amd_pkg::V_MUSIC},
    '{amd_pkg::MODE_EVENT, 6'd0,  amd_pkg::EV_IGN_LAST,   1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd0,  EV_OTHER_LAST,          1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_SIL_TONE,   1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_SIL_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_SIL_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd63, amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_START, 6'd1,  amd_pkg::EV_IGN_FIRST,  1'b1, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd1,  amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd1,  amd_pkg::EV_SIL_PERSON, 1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd1,  amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd1,  amd_pkg::EV_SIL_TOUT,   1'b1, amd_pkg::V_NONE},
    '{amd_pkg::MODE_START, 6'd2,  amd_pkg::EV_IGN_FIRST,  1'b1, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd2,  amd_pkg::EV_VOC_MIN,    1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd2,  amd_pkg::EV_MUSIC,      1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_EVENT, 6'd2,  amd_pkg::EV_VOC_TOUT,   1'b0, amd_pkg::V_NONE},
    '{amd_pkg::MODE_STOP,  6'd63, EV_OTHER_FIRST,         1'b1, amd_pkg::V_NONE}
  };

  function automatic void clear_chan(input ch_t ch);
    chan_on[ch]      = 1'b0;
    short_sil[ch]    = '0;
    tone_sil[ch]     = '0;
    person_sil[ch]   = '0;
    short_voc[ch]    = '0;
    music_cnt[ch]    = '0;
    person_seen[ch]  = 1'b0;
    tone_seen[ch]    = 1'b0;
    last_event[ch]   = amd_pkg::EV_IGN_FIRST;
    last_verdict[ch] = amd_pkg::V_NONE;
  endfunction

  function automatic count_t bump(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic count_t drop(input count_t v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic vcode_t classify_event(input ch_t ch, input ev_t ev);
    vcode_t v;
    ev_t prev;
    v = amd_pkg::V_NONE;
    prev = last_event[ch];
    if (!chan_on[ch]) begin
      clear_chan(ch);
      return amd_pkg::V_NONE;
    end
    if (ev >= amd_pkg::EV_SIL_MIN) begin
      case (ev)
        amd_pkg::EV_SIL_MIN: short_sil[ch] = bump(short_sil[ch]);
        amd_pkg::EV_SIL_TONE: begin
          tone_sil[ch] = bump(tone_sil[ch]);
          if (prev == amd_pkg::EV_SIL_MIN) short_sil[ch] = drop(short_sil[ch]);
        end
        amd_pkg::EV_SIL_PERSON: begin
          if (tone_sil[ch] != '0 && prev == amd_pkg::EV_SIL_TONE) begin
            tone_sil[ch] = tone_sil[ch] - 1'b1;
            tone_seen[ch] = 1'b0;
          end
          if (short_voc[ch] != '0 || music_cnt[ch] != '0) begin
            if (person_sil[ch] == '0) person_seen[ch] = 1'b0;
            person_sil[ch] = bump(person_sil[ch]);
          end
        end
        amd_pkg::EV_SIL_TOUT: begin
          if (prev == amd_pkg::EV_SIL_PERSON) person_sil[ch] = drop(person_sil[ch]);
        end
        amd_pkg::EV_VOC_MIN: begin
          short_voc[ch] = bump(short_voc[ch]);
          if (person_sil[ch] != '0) person_seen[ch] = 1'b1;
          if (tone_sil[ch] != '0) tone_seen[ch] = 1'b1;
        end
        amd_pkg::EV_MUSIC: begin
          if (prev == amd_pkg::EV_VOC_MIN) short_voc[ch] = drop(short_voc[ch]);
          music_cnt[ch] = bump(music_cnt[ch]);
        end
        amd_pkg::EV_VOC_TOUT: begin
          if (prev == amd_pkg::EV_MUSIC) music_cnt[ch] = drop(music_cnt[ch]);
        end
        default: ;
      endcase
      last_event[ch] = ev;
    end
    if (music_cnt[ch] != '0) begin
      music_cnt[ch] = '0;
      short_sil[ch] = '0;
      short_voc[ch] = '0;
      tone_seen[ch] = 1'b0;
      last_verdict[ch] = amd_pkg::V_MUSIC;
      v = amd_pkg::V_MUSIC;
    end else if (person_seen[ch] && last_verdict[ch] != amd_pkg::V_PERSON &&
                 last_verdict[ch] != amd_pkg::V_TONE) begin
      last_verdict[ch] = amd_pkg::V_PERSON;
      chan_on[ch] = 1'b0;
      v = amd_pkg::V_PERSON;
    end
    if (last_verdict[ch] != amd_pkg::V_PERSON && last_verdict[ch] != amd_pkg::V_TONE &&
        short_voc[ch] > voice_thr && short_sil[ch] > sil_thr && tone_seen[ch]) begin
      music_cnt[ch] = '0;
      short_sil[ch] = '0;
      short_voc[ch] = '0;
      tone_seen[ch] = 1'b0;
      last_verdict[ch] = amd_pkg::V_TONE;
      v = amd_pkg::V_TONE;
    end
    return v;
  endfunction

  function automatic vcode_t classify_item(input mode_t mode, input ch_t ch, input ev_t ev);
    case (mode)
      amd_pkg::MODE_EVENT: return classify_event(ch, ev);
      amd_pkg::MODE_START: begin
        clear_chan(ch);
        chan_on[ch] = 1'b1;
      end
      amd_pkg::MODE_STOP: clear_chan(ch);
      default: ;
    endcase
    return amd_pkg::V_NONE;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_verdicts
    verdict_t due;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          amd_pkg::REG_VOICE_THR: voice_thr = cfg.data;
          amd_pkg::REG_SIL_THR: sil_thr = cfg.data;
          default: ;
        endcase
      end
      if (evt.valid && evt.ready) begin
        due.verdict = classify_item(evt.mode, evt.channel, evt.event_code);
        due.ch = evt.channel;
        if (row_fixed) due.verdict = row_verdict;
        verdicts_due.push_back(due);
      end
      if (res.valid && res.ready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("unexpected result, verdict", int'(res.verdict),
                        int'(amd_pkg::V_NONE));
        end else begin
          due = verdicts_due.pop_front();
          if (res.verdict !== due.verdict)
            flag_mismatch("verdict", int'(res.verdict), int'(due.verdict));
          if (res.verdict_channel !== due.ch)
            flag_mismatch("verdict_channel", int'(res.verdict_channel), int'(due.ch));
        end
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_offs_done;
    hold_left = 0;
    hold_offs_done = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_offs_done != hold_offs_asked) begin
        hold_offs_done = hold_offs_asked;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready = 1'b0;
      end else begin
        res.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic offer_item(input mode_t mode, input ch_t ch, input ev_t ev, input bit fixed,
                            input vcode_t fixed_v);
    while ($urandom_range(99) < send_idle_pct) begin
      evt.valid = 1'b0;
      @(negedge clk_i);
    end
    evt.valid = 1'b1;
    evt.mode = mode;
    evt.channel = ch;
    evt.event_code = ev;
    row_fixed = fixed;
    row_verdict = fixed_v;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [amd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [amd_pkg::CFG_DATA_W-1:0] d);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = d;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic drain;
    evt.valid = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic start_phase(input logic [amd_pkg::THR_W-1:0] vthr,
                             input logic [amd_pkg::THR_W-1:0] sthr,
                             input int sidle, input int ridle);
    drain();
    write_reg(amd_pkg::REG_VOICE_THR, vthr);
    write_reg(amd_pkg::REG_SIL_THR, sthr);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int k = 0; k < POOL_N; k++) pool[k] = ch_t'($urandom_range(NCH - 1));
  endtask

  function automatic ev_t pick_event;
    int r;
    r = $urandom_range(99);
    if (r < 80) return ev_t'($urandom_range(amd_pkg::EV_VOC_TOUT, amd_pkg::EV_SIL_MIN));
    if (r < 90) return ev_t'($urandom_range(amd_pkg::EV_IGN_LAST, amd_pkg::EV_IGN_FIRST));
    return ev_t'($urandom_range(EV_OTHER_LAST, EV_OTHER_FIRST));
  endfunction

  task automatic random_calls(input int n, input int hold_at);
    int r;
    ch_t ch;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_offs_asked++;
      r = $urandom_range(99);
      if ($urandom_range(99) < 5) ch = ch_t'($urandom_range(NCH - 1));
      else ch = pool[$urandom_range(POOL_N - 1)];
      if (r < 4) offer_item(MODE_UNUSED, ch_t'($urandom_range(NCH - 1)),
                            ev_t'($urandom_range(15)), 1'b0, amd_pkg::V_NONE);
      else if (r < 7) offer_item(amd_pkg::MODE_STOP, ch, ev_t'($urandom_range(15)), 1'b0,
                                 amd_pkg::V_NONE);
      else if (r < 17) offer_item(amd_pkg::MODE_START, ch, ev_t'($urandom_range(15)), 1'b0,
                                  amd_pkg::V_NONE);
      else offer_item(amd_pkg::MODE_EVENT, ch, pick_event(), 1'b0, amd_pkg::V_NONE);
    end
  endtask

  task automatic saturate(input ev_t ev, input ev_t tail_a, input ev_t tail_b);
    ch_t ch;
    ch = ch_t'($urandom_range(NCH - 1));
    offer_item(amd_pkg::MODE_START, ch, amd_pkg::EV_IGN_FIRST, 1'b0, amd_pkg::V_NONE);
    offer_item(amd_pkg::MODE_EVENT, ch, amd_pkg::EV_VOC_MIN, 1'b0, amd_pkg::V_NONE);
    repeat (BURST_N) offer_item(amd_pkg::MODE_EVENT, ch, ev, 1'b0, amd_pkg::V_NONE);
    offer_item(amd_pkg::MODE_EVENT, ch, tail_a, 1'b0, amd_pkg::V_NONE);
    offer_item(amd_pkg::MODE_EVENT, ch, tail_b, 1'b0, amd_pkg::V_NONE);
  endtask

  initial begin : stimulus
    evt.valid = 1'b0;
    evt.mode = amd_pkg::MODE_EVENT;
    evt.channel = '0;
    evt.event_code = amd_pkg::EV_IGN_FIRST;
    cfg.valid = 1'b0;
    cfg.index = amd_pkg::REG_VOICE_THR;
    cfg.data = '0;
    for (int c = 0; c < NCH; c++) clear_chan(ch_t'(c));
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    start_phase(amd_pkg::VOICE_THR_RST, amd_pkg::SIL_THR_RST, 22, 47);
    for (int i = 0; i < ROWS; i++)
      offer_item(call_rows[i].mode, call_rows[i].ch, call_rows[i].ev, call_rows[i].fixed,
                 call_rows[i].verdict);
    random_calls(150, -1);

    start_phase(8'd0, 8'd0, 22, 47);
    random_calls(150, -1);
    saturate(amd_pkg::EV_SIL_MIN, amd_pkg::EV_SIL_TONE, amd_pkg::EV_VOC_MIN);

    start_phase(8'd255, 8'd255, 47, 22);
    send_idle_pct = 0;
    random_calls(60, 10);
    send_idle_pct = 47;
    random_calls(90, -1);

    start_phase(8'd2, 8'd3, 47, 22);
    saturate(amd_pkg::EV_SIL_PERSON, amd_pkg::EV_SIL_TOUT, amd_pkg::EV_VOC_MIN);

    start_phase(8'd1, 8'd0, 0, 0);
    random_calls(150, -1);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
